>>> rtl/spha_pkg.sv
// Shared constants, codes and controller/datapath bundles for the sparse
// product hash accumulator. No dependencies; every other file imports it.
`default_nettype none

package spha_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int OFFSET_BITS = 24;
	localparam int VAL_W = 32;
	localparam int TAG_W = OFFSET_BITS + 1;
	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = SLOT_W + 1;
	localparam int SIZE_W = 7;
	localparam int SIZE_RESET = 64;
	localparam int KIND_W = 2;

	localparam int REM_BITS = 5;
	localparam int REM_STEPS = (TAG_W + REM_BITS - 1) / REM_BITS;
	localparam int REM_PAD_W = REM_STEPS * REM_BITS;
	localparam int REM_CNT_W = $clog2(REM_STEPS);

	localparam int S_TDATA_W = ((2 * VAL_W + 2 * OFFSET_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((TAG_W + VAL_W + 7) / 8) * 8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_SIZE_IDX = '0;

	localparam logic [KIND_W-1:0] KIND_ENTRY = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_EMPTY = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = KIND_W'(2);

	localparam int SLOT_OP_W = 3;
	localparam logic [SLOT_OP_W-1:0] SLOT_HOLD = SLOT_OP_W'(0);
	localparam logic [SLOT_OP_W-1:0] SLOT_HOME = SLOT_OP_W'(1);
	localparam logic [SLOT_OP_W-1:0] SLOT_ZERO = SLOT_OP_W'(2);
	localparam logic [SLOT_OP_W-1:0] SLOT_PROBE_INC = SLOT_OP_W'(3);
	localparam logic [SLOT_OP_W-1:0] SLOT_SCAN_INC = SLOT_OP_W'(4);

	typedef struct packed {
		logic load;
		logic [SLOT_OP_W-1:0] slot_op;
		logic step_clr;
		logic step_inc;
		logic rd_en;
		logic wr_en;
		logic wr_add;
		logic clr_valid;
		logic out_load;
		logic [KIND_W-1:0] out_kind;
	} spha_cmd_t;

	typedef struct packed {
		logic rem_busy;
		logic valid_at_slot;
		logic tag_match;
		logic step_last;
		logic slot_end;
		logic any_valid;
		logic any_above;
		logic out_free;
	} spha_status_t;

endpackage

`default_nettype wire

>>> rtl/sparse_product_hash_accumulator.sv
// Top level of the sparse product hash accumulator: stream ports, the
// configuration register, controller and datapath. Depends on spha_pkg.
//
// One item is worked on at a time; s_tready is high only while the block is
// idle, and a result waiting in the output register does not hold off the
// next item. An accumulate item is accepted, steps through the
// remainder unit (five tag bits a cycle), sets the home slot, and then
// writes at once if the home slot is empty, or reads and compares each
// probed occupied slot, since every probe reads the slot memory through its
// registered read port; an overflow then delivers its result through the
// output register, waiting while that register is still held.
// A flush scans the slots up to the highest occupied one and delivers each
// entry, waiting while the output stalls; an empty flush delivers one empty
// result. Flush clears each slot as it is emitted, so no clearing pass is
// needed after reset or between frames.
`default_nettype none

module sparse_product_hash_accumulator
	import spha_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input item.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// tdata fields from bit 0: x_value, y_value, x_offset, y_offset.
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// tuser fields from bit 0: opcode.
	input  wire logic [0:0]            s_tuser,
	// Result item.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// tdata fields from bit 0: out_index, sum_value, zero padding.
	output logic [M_TDATA_W-1:0]       m_tdata,
	// tuser fields from bit 0: kind.
	output logic [KIND_W-1:0]          m_tuser,
	output logic                       m_tlast,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready
);

	logic [SIZE_W-1:0] size_q;
	logic              size_sel;
	spha_cmd_t         cmd;
	spha_status_t      st;

	assign pready = 1'b1;
	assign size_sel = (paddr[PADDR_W-1:2] == REG_SIZE_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RESET);
		end else if (psel && penable && pwrite && pready && size_sel) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign prdata = size_sel ? PDATA_W'(size_q) : '0;

	spha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (s_tuser[0]),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	spha_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.size_q   (size_q),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

>>> rtl/spha_rem.sv
// Iterative remainder unit: tag modulo the table size in use, several
// dividend bits per cycle. Depends on spha_pkg.
`default_nettype none

module spha_rem
	import spha_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TAG_W-1:0]  dividend,
	input  wire logic [CNT_W-1:0]  modulus,
	output logic                   busy,
	output logic [SLOT_W-1:0]      rem
);

	logic                 busy_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic [REM_PAD_W-1:0] shift_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     rem_d;

	always_comb begin
		rem_d = rem_q;
		for (int b = 0; b < REM_BITS; b++) begin
			rem_d = {rem_d[SLOT_W-1:0], shift_q[REM_PAD_W-1-b]};
			if (rem_d >= modulus) begin
				rem_d = rem_d - modulus;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= REM_CNT_W'(REM_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - REM_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= REM_PAD_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << REM_BITS;
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign rem = rem_q[SLOT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/spha_dp.sv
// Datapath: multiplier, tag adder, remainder unit, slot memories, valid bits
// and the output register. Depends on spha_pkg and spha_rem.
`default_nettype none

module spha_dp
	import spha_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic [SIZE_W-1:0]     size_q,
	input  wire spha_cmd_t             cmd,
	output spha_status_t               st,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic [KIND_W-1:0]          m_tuser,
	output logic                       m_tlast
);

	logic [VAL_W-1:0]       x_value;
	logic [VAL_W-1:0]       y_value;
	logic [OFFSET_BITS-1:0] x_offset;
	logic [OFFSET_BITS-1:0] y_offset;
	logic [VAL_W-1:0]       prod_d;
	logic [TAG_W-1:0]       tag_d;
	logic [CNT_W-1:0]       n_used;

	logic [VAL_W-1:0]       prod_q;
	logic [TAG_W-1:0]       tag_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      step_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [TAG_W-1:0]       tag_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]       sum_mem [TABLE_DEPTH];
	logic [TAG_W-1:0]       rd_tag_q;
	logic [VAL_W-1:0]       rd_sum_q;
	logic [VAL_W-1:0]       wr_sum;

	logic                   out_valid_q;
	logic [KIND_W-1:0]      out_kind_q;
	logic [TAG_W-1:0]       out_idx_q;
	logic [VAL_W-1:0]       out_sum_q;
	logic                   out_last_q;

	logic                   rem_busy;
	logic [SLOT_W-1:0]      home_slot;
	logic [CNT_W-1:0]       slot_inc;
	logic [SLOT_W-1:0]      probe_next;
	logic [TABLE_DEPTH-1:0] hi_mask;
	logic                   out_free;

	assign x_value = s_tdata[VAL_W-1:0];
	assign y_value = s_tdata[2*VAL_W-1:VAL_W];
	assign x_offset = s_tdata[2*VAL_W +: OFFSET_BITS];
	assign y_offset = s_tdata[2*VAL_W+OFFSET_BITS +: OFFSET_BITS];
	assign prod_d = x_value * y_value;
	assign tag_d = TAG_W'(x_offset) + TAG_W'(y_offset);

	always_comb begin
		if (size_q == '0) begin
			n_used = CNT_W'(1);
		end else if (32'(size_q) > 32'(TABLE_DEPTH)) begin
			n_used = CNT_W'(TABLE_DEPTH);
		end else begin
			n_used = CNT_W'(size_q);
		end
	end

	spha_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (tag_d),
		.modulus  (n_used),
		.busy     (rem_busy),
		.rem      (home_slot)
	);

	assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);
	assign probe_next = (slot_inc == n_used) ? '0 : slot_inc[SLOT_W-1:0];
	assign hi_mask = {TABLE_DEPTH{1'b1}} << slot_inc;
	assign wr_sum = cmd.wr_add ? (rd_sum_q + prod_q) : prod_q;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_q <= prod_d;
			tag_q <= tag_d;
		end
		if (cmd.step_clr) begin
			step_q <= '0;
		end else if (cmd.step_inc) begin
			step_q <= step_q + SLOT_W'(1);
		end
		case (cmd.slot_op)
			SLOT_HOME: slot_q <= home_slot;
			SLOT_ZERO: slot_q <= '0;
			SLOT_PROBE_INC: slot_q <= probe_next;
			SLOT_SCAN_INC: slot_q <= slot_inc[SLOT_W-1:0];
			default: slot_q <= slot_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			tag_mem[slot_q] <= tag_q;
			sum_mem[slot_q] <= wr_sum;
		end
		if (cmd.rd_en) begin
			rd_tag_q <= tag_mem[slot_q];
			rd_sum_q <= sum_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[slot_q] <= 1'b1;
		end else if (cmd.clr_valid) begin
			valid_q[slot_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind_q <= cmd.out_kind;
			case (cmd.out_kind)
				KIND_ENTRY: begin
					out_idx_q <= rd_tag_q;
					out_sum_q <= rd_sum_q;
					out_last_q <= !(|(valid_q & hi_mask));
				end
				KIND_OVERFLOW: begin
					out_idx_q <= tag_q;
					out_sum_q <= prod_q;
					out_last_q <= 1'b1;
				end
				default: begin
					out_idx_q <= '0;
					out_sum_q <= '0;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign st.rem_busy = rem_busy;
	assign st.valid_at_slot = valid_q[slot_q];
	assign st.tag_match = (rd_tag_q == tag_q);
	assign st.step_last = (CNT_W'(step_q) == n_used - CNT_W'(1));
	assign st.slot_end = (slot_q == SLOT_W'(TABLE_DEPTH - 1));
	assign st.any_valid = |valid_q;
	assign st.any_above = |(valid_q & hi_mask);
	assign st.out_free = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata = M_TDATA_W'({out_sum_q, out_idx_q});
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("Result loaded while the output register is still held.");

	a_claim_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && !cmd.wr_add) |-> !valid_q[slot_q])
		else $error("New tag claimed an occupied slot.");

	a_clear_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_valid |-> (valid_q[slot_q] && !cmd.wr_en))
		else $error("Flush cleared a slot that holds no entry.");

endmodule

`default_nettype wire

>>> rtl/spha_ctrl.sv
// Controller state machine: sequences accept, remainder, probing and flush.
// Depends on spha_pkg; drives the datapath through spha_cmd_t.
`default_nettype none

module spha_ctrl
	import spha_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         opcode,
	output logic              s_tready,
	input  wire spha_status_t st,
	output spha_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_REM     = 3'd1;
	localparam logic [2:0] ST_PR_CHK  = 3'd2;
	localparam logic [2:0] ST_PR_CMP  = 3'd3;
	localparam logic [2:0] ST_OVF     = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;
	localparam logic [2:0] ST_FL_SCAN = 3'd6;
	localparam logic [2:0] ST_FL_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.slot_op = SLOT_HOLD;
		cmd.out_kind = KIND_ENTRY;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cmd.slot_op = SLOT_ZERO;
					if (!opcode) begin
						state_d = ST_REM;
					end else if (st.any_valid) begin
						state_d = ST_FL_SCAN;
					end else begin
						state_d = ST_EMPTY;
					end
				end
			end
			ST_REM: begin
				if (!st.rem_busy) begin
					cmd.slot_op = SLOT_HOME;
					cmd.step_clr = 1'b1;
					state_d = ST_PR_CHK;
				end
			end
			ST_PR_CHK: begin
				if (!st.valid_at_slot) begin
					cmd.wr_en = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d = ST_PR_CMP;
				end
			end
			ST_PR_CMP: begin
				if (st.tag_match) begin
					cmd.wr_en = 1'b1;
					cmd.wr_add = 1'b1;
					state_d = ST_IDLE;
				end else if (st.step_last) begin
					state_d = ST_OVF;
				end else begin
					cmd.slot_op = SLOT_PROBE_INC;
					cmd.step_inc = 1'b1;
					state_d = ST_PR_CHK;
				end
			end
			ST_OVF: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_OVERFLOW;
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_EMPTY;
					state_d = ST_IDLE;
				end
			end
			ST_FL_SCAN: begin
				if (st.valid_at_slot) begin
					cmd.rd_en = 1'b1;
					state_d = ST_FL_OUT;
				end else if (st.slot_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.slot_op = SLOT_SCAN_INC;
				end
			end
			ST_FL_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_ENTRY;
					cmd.clr_valid = 1'b1;
					if (st.any_above) begin
						cmd.slot_op = SLOT_SCAN_INC;
						state_d = ST_FL_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> tb/sparse_product_hash_accumulator_tb.sv
// Self-checking regression for the sparse product hash accumulator: directed cases, then
// random phases under varied stream idling, checked against an in-bench hash table model.
// Depends on spha_pkg and the sparse_product_hash_accumulator RTL.
`timescale 1ns / 100ps

module sparse_product_hash_accumulator_tb;
	import spha_pkg::*;

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_FLUSH = 1'b1;
	localparam int SETTLE_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0] tag;
		logic [VAL_W-1:0] total;
		logic last;
	} hash_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	logic [SIZE_W-1:0] size_reg = SIZE_W'(SIZE_RESET);
	bit tbl_valid [TABLE_DEPTH];
	logic [TAG_W-1:0] tbl_tag [TABLE_DEPTH];
	logic [VAL_W-1:0] tbl_sum [TABLE_DEPTH];
	hash_result_t due_results [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int overflows_seen = 0;
	int items_sent = 0;
	int phases_run = 0;
	int quiet_cycles = 0;

	sparse_product_hash_accumulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic apply_to_table(input logic op, input logic [VAL_W-1:0] xv, yv,
			input logic [OFFSET_BITS-1:0] xo, yo);
		logic [VAL_W-1:0] prod;
		logic [TAG_W-1:0] tag;
		int n;
		int slot;
		int lastpos;
		bit placed;
		if (op == OP_ACCUM) begin
			prod = xv * yv;
			tag = TAG_W'(xo) + TAG_W'(yo);
			n = int'(size_reg);
			if (n < 1) n = 1;
			if (n > TABLE_DEPTH) n = TABLE_DEPTH;
			slot = int'(tag) % n;
			placed = 1'b0;
			for (int step = 0; step < n && !placed; step++) begin
				if (!tbl_valid[slot]) begin
					tbl_valid[slot] = 1'b1;
					tbl_tag[slot] = tag;
					tbl_sum[slot] = prod;
					placed = 1'b1;
				end else if (tbl_tag[slot] == tag) begin
					tbl_sum[slot] = tbl_sum[slot] + prod;
					placed = 1'b1;
				end else begin
					slot = (slot + 1 == n) ? 0 : slot + 1;
				end
			end
			if (!placed) due_results.push_back('{KIND_OVERFLOW, tag, prod, 1'b1});
		end else begin
			lastpos = -1;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (tbl_valid[i]) begin
					due_results.push_back('{KIND_ENTRY, tbl_tag[i], tbl_sum[i], 1'b0});
					lastpos = due_results.size() - 1;
					tbl_valid[i] = 1'b0;
				end
			end
			if (lastpos < 0) due_results.push_back('{KIND_EMPTY, '0, '0, 1'b1});
			else due_results[lastpos].last = 1'b1;
		end
	endtask

	task automatic send_item(input logic op, input logic [VAL_W-1:0] xv, yv,
			input logic [OFFSET_BITS-1:0] xo, yo);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {yo, xo, yv, xv};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_to_table(op, xv, yv, xo, yo);
		items_sent++;
	endtask

	task automatic settle(input int extra);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_size(input logic [PDATA_W-1:0] word);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({REG_SIZE_IDX, 2'b00});
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_reg = word[SIZE_W-1:0];
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return VAL_W'($urandom_range(16));
			default: return $urandom;
		endcase
	endfunction

	task automatic test_extremes();
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom), OFFSET_BITS'($urandom));
		send_item(OP_ACCUM, 32'h8000_0000, 32'h8000_0000, '1, '1);
		send_item(OP_ACCUM, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0, '0);
		send_item(OP_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0);
		send_item(OP_ACCUM, 32'd5, -32'sd3, 24'd2, 24'd3);
		send_item(OP_ACCUM, 32'd7, 32'd11, 24'd60, 24'd9);
		send_item(OP_ACCUM, 32'd1, 32'd1, 24'd0, 24'd69);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd0, 24'd63);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd100, 24'd27);
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom), OFFSET_BITS'($urandom));
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom), OFFSET_BITS'($urandom));
		settle(SETTLE_CYCLES);
	endtask

	task automatic test_size_limits();
		write_size(32'hFFFF_FF80);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd4, 24'd6);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd5, 24'd6);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd6, 24'd4);
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom), OFFSET_BITS'($urandom));
		settle(SETTLE_CYCLES);
		write_size(32'h0000_007F);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd50, 24'd50);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd64, 24'd100);
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom), OFFSET_BITS'($urandom));
		settle(SETTLE_CYCLES);
		write_size(32'd2);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd4, 24'd0);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd5, 24'd0);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd6, 24'd0);
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom), OFFSET_BITS'($urandom));
		settle(SETTLE_CYCLES);
	endtask

	task automatic test_shrunk_size();
		write_size(32'd64);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd60, 24'd0);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd61, 24'd0);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd1, 24'd2);
		settle(SETTLE_CYCLES);
		write_size(32'd4);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd3, 24'd0);
		send_item(OP_ACCUM, $urandom, $urandom, 24'd7, 24'd0);
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom), OFFSET_BITS'($urandom));
		settle(SETTLE_CYCLES);
	endtask

	task automatic test_random_phase(input int idle, input int stall,
			input logic [PDATA_W-1:0] size_word, input int span, input int flush_pct,
			input int count);
		idle_pct = idle;
		stall_pct = stall;
		settle(SETTLE_CYCLES);
		write_size(size_word);
		for (int k = 0; k < count; k++) begin
			logic [OFFSET_BITS-1:0] xo;
			logic [OFFSET_BITS-1:0] yo;
			int mode;
			mode = $urandom_range(9);
			if (mode < 2) begin
				xo = OFFSET_BITS'($urandom);
				yo = OFFSET_BITS'($urandom);
			end else if (mode == 2) begin
				xo = '1 - OFFSET_BITS'($urandom_range(3));
				yo = '1 - OFFSET_BITS'($urandom_range(3));
			end else begin
				xo = OFFSET_BITS'($urandom_range(span));
				yo = OFFSET_BITS'($urandom_range(span));
			end
			if ($urandom_range(99) < flush_pct)
				send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom),
					OFFSET_BITS'($urandom));
			else
				send_item(OP_ACCUM, pick_value(), pick_value(), xo, yo);
			if (k % 40 == 39) settle(0);
		end
		send_item(OP_FLUSH, $urandom, $urandom, OFFSET_BITS'($urandom),
			OFFSET_BITS'($urandom));
		phases_run++;
	endtask

	always @(posedge clk) begin
		hash_result_t got;
		hash_result_t want;
		if (m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[TAG_W-1:0], m_tdata[TAG_W+VAL_W-1:TAG_W], m_tlast};
			results_seen++;
			if (got.kind == KIND_OVERFLOW) overflows_seen++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d tag %h total %h last %b",
						got.kind, got.tag, got.total, got.last);
			end else begin
				want = due_results.pop_front();
				if (got !== want || m_tdata[M_TDATA_W-1:TAG_W+VAL_W] !== '0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d: expected kind %0d tag %h total %h last %b",
							results_seen, want.kind, want.tag, want.total, want.last);
						$display("result %0d: got kind %0d tag %h total %h last %b pad %h",
							results_seen, got.kind, got.tag, got.total, got.last,
							m_tdata[M_TDATA_W-1:TAG_W+VAL_W]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("sparse_product_hash_accumulator regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_size_limits();
		test_shrunk_size();
		test_random_phase(0, 0, 32'd64, 40, 2, 97);
		test_random_phase(70, 0, ($urandom & 32'hFFFF_FF80) | 32'd13, 12, 8, 97);
		test_random_phase(0, 70, ($urandom & 32'hFFFF_FF80) | $urandom_range(65, 127),
			40, 3, 97);
		test_random_phase(34, 34, ($urandom & 32'hFFFF_FF80) | 32'd5, 6, 10, 97);
		settle(SETTLE_CYCLES);
		$display("Covered %0d items over directed cases and %0d random phases.",
			items_sent, phases_run);
		$display("Checked %0d results, %0d of them overflows, with %0d mismatches.",
			results_seen, overflows_seen, mismatches);
		if (mismatches == 0)
			$display("sparse_product_hash_accumulator regression: pass");
		else
			$display("sparse_product_hash_accumulator regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/spha_pkg.sv
rtl/spha_rem.sv
rtl/spha_dp.sv
rtl/spha_ctrl.sv
rtl/sparse_product_hash_accumulator.sv
tb/sparse_product_hash_accumulator_tb.sv
